// ===== rtl/core/radiometric_frame_decoder_macros.svh =====
// Assertion macros used by the radiometric frame decoder back part.
`ifndef RADIOMETRIC_FRAME_DECODER_MACROS_SVH
`define RADIOMETRIC_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, reset masked.
`define RFD_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define RFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rfd_pkg.sv =====
// Shared types, constants and helpers of the radiometric frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 256;
    localparam int unsigned MAX_ROWS_DEF  = 256;

    localparam int unsigned DIM_W    = 9;
    localparam int unsigned RAW_W    = 16;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned CNT_W    = 17;
    localparam int unsigned TEMP_W   = 18;
    localparam int unsigned STATUS_W = 2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] THERMAL_ROWS_RST = 9'd192;

    localparam logic [RAW_W-1:0] VALID_RAW_MIN = 16'd11082;
    localparam logic signed [TEMP_W-1:0] KELVIN_OFFSET = 18'sd27315;

    // numerator = raw_sum*25 + count*8 (37 bits); divide by 16 up front
    localparam int unsigned NUM_W     = 37;
    localparam int unsigned DIV_NUM_W = NUM_W - 4;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_THERMAL_ROWS = 1'b1;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CALIBRATION = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW     = 2'd2;

    // front -> back queue item; the frame stats are meaningful on frame_end only
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             valid;
        logic             frame_end;
        logic [RAW_W-1:0] min_raw;
        logic [RAW_W-1:0] max_raw;
        logic [SUM_W-1:0] raw_sum;
        logic [CNT_W-1:0] good_count;
        logic [CNT_W-1:0] total;
    } rfd_entry_t;

    // round_half_up(raw*25/16) - 27315, in 0.01 C
    function automatic logic signed [TEMP_W-1:0] raw_to_centi(input logic [RAW_W-1:0] raw);
        logic [20:0] scaled;
        logic [16:0] kelvin;
        scaled = ({5'd0, raw} << 4) + ({5'd0, raw} << 3) + {5'd0, raw} + 21'd8;
        kelvin = scaled[20:4];
        return $signed({1'b0, kelvin}) - KELVIN_OFFSET;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rfd_front.sv =====
// Front part: accepts pixels, classifies them and keeps the running frame stats.
`timescale 1ns / 1ps
`default_nettype none

module rfd_front #(
    parameter int unsigned MAX_WIDTH = rfd_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_ROWS  = rfd_pkg::MAX_ROWS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [rfd_pkg::DIM_W-1:0]   frame_width,
    input  wire logic [rfd_pkg::DIM_W-1:0]   thermal_rows,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [15:0]                 s_tdata,    // [7:0] low_byte, [15:8] high_byte
    input  wire logic                        q_full,
    output logic                             q_push,
    output rfd_pkg::rfd_entry_t              q_entry
);

    logic [rfd_pkg::CNT_W-1:0] pixel_index_reg, pixel_index_next;
    logic [rfd_pkg::RAW_W-1:0] min_raw_reg, min_raw_next;
    logic [rfd_pkg::RAW_W-1:0] max_raw_reg, max_raw_next;
    logic [rfd_pkg::SUM_W-1:0] raw_sum_reg, raw_sum_next;
    logic [rfd_pkg::CNT_W-1:0] good_count_reg, good_count_next;

    logic [rfd_pkg::DIM_W-1:0] width_eff, rows_eff;
    logic [2*rfd_pkg::DIM_W-1:0] total_full;
    logic [rfd_pkg::CNT_W-1:0] total;
    logic [rfd_pkg::RAW_W-1:0] raw;
    logic                      valid;
    logic [rfd_pkg::CNT_W-1:0] index_inc;
    logic                      frame_end;

    always_comb begin
        if (frame_width == '0) begin
            width_eff = rfd_pkg::DIM_W'(1);
        end else if (frame_width > rfd_pkg::DIM_W'(MAX_WIDTH)) begin
            width_eff = rfd_pkg::DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = frame_width;
        end
        if (thermal_rows == '0) begin
            rows_eff = rfd_pkg::DIM_W'(1);
        end else if (thermal_rows > rfd_pkg::DIM_W'(MAX_ROWS)) begin
            rows_eff = rfd_pkg::DIM_W'(MAX_ROWS);
        end else begin
            rows_eff = thermal_rows;
        end
    end

    assign total_full = width_eff * rows_eff;
    assign total      = total_full[rfd_pkg::CNT_W-1:0];

    assign raw       = {s_tdata[15:8], s_tdata[7:0]};
    assign valid     = (raw >= rfd_pkg::VALID_RAW_MIN);
    assign index_inc = pixel_index_reg + rfd_pkg::CNT_W'(1);
    assign frame_end = (index_inc >= total);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        min_raw_next    = min_raw_reg;
        max_raw_next    = max_raw_reg;
        raw_sum_next    = raw_sum_reg;
        good_count_next = good_count_reg;
        if (valid) begin
            if (raw < min_raw_reg) begin
                min_raw_next = raw;
            end
            if (raw > max_raw_reg) begin
                max_raw_next = raw;
            end
            raw_sum_next    = raw_sum_reg + rfd_pkg::SUM_W'(raw);
            good_count_next = good_count_reg + rfd_pkg::CNT_W'(1);
        end
        pixel_index_next = index_inc;
    end

    always_comb begin
        q_entry.raw        = raw;
        q_entry.valid      = valid;
        q_entry.frame_end  = frame_end;
        q_entry.min_raw    = min_raw_next;
        q_entry.max_raw    = max_raw_next;
        q_entry.raw_sum    = raw_sum_next;
        q_entry.good_count = good_count_next;
        q_entry.total      = total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_index_reg <= '0;
            min_raw_reg     <= '1;
            max_raw_reg     <= '0;
            raw_sum_reg     <= '0;
            good_count_reg  <= '0;
        end else if (q_push) begin
            if (frame_end) begin
                pixel_index_reg <= '0;
                min_raw_reg     <= '1;
                max_raw_reg     <= '0;
                raw_sum_reg     <= '0;
                good_count_reg  <= '0;
            end else begin
                pixel_index_reg <= pixel_index_next;
                min_raw_reg     <= min_raw_next;
                max_raw_reg     <= max_raw_next;
                raw_sum_reg     <= raw_sum_next;
                good_count_reg  <= good_count_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rfd_queue.sv =====
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module rfd_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire rfd_pkg::rfd_entry_t  push_entry,
    input  wire logic                 pop,
    output rfd_pkg::rfd_entry_t       head,
    output logic                      empty,
    output logic                      full
);

    rfd_pkg::rfd_entry_t slot_reg [rfd_pkg::QUEUE_DEPTH];

    logic [rfd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rfd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [rfd_pkg::QPTR_W:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (rfd_pkg::QPTR_W+1)'(rfd_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (rfd_pkg::QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (rfd_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + rfd_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rfd_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rfd_divider.sv =====
// Restoring divider for the frame mean, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rfd_divider (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [rfd_pkg::DIV_NUM_W-1:0]   dividend,
    input  wire logic [rfd_pkg::CNT_W-1:0]       divisor,
    output logic                                 busy,
    output logic [rfd_pkg::CNT_W-1:0]            quotient
);

    localparam int unsigned STEP_W = $clog2(rfd_pkg::DIV_NUM_W + 1);

    logic [rfd_pkg::DIV_NUM_W-1:0] acc_reg, acc_next;   // dividend out, quotient in
    logic [rfd_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [rfd_pkg::CNT_W-1:0]     den_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          busy_reg;

    logic [rfd_pkg::CNT_W:0] rem_sh;
    logic [rfd_pkg::CNT_W:0] diff;
    logic                    ge;

    assign rem_sh = {rem_reg, acc_reg[rfd_pkg::DIV_NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb begin
        rem_next = ge ? diff[rfd_pkg::CNT_W-1:0] : rem_sh[rfd_pkg::CNT_W-1:0];
        acc_next = {acc_reg[rfd_pkg::DIV_NUM_W-2:0], ge};
    end

    assign busy     = busy_reg;
    assign quotient = acc_reg[rfd_pkg::CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(rfd_pkg::DIV_NUM_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rfd_back.sv =====
// Back part: drains the queue, converts pixels and builds the frame summary.
`timescale 1ns / 1ps
`default_nettype none
`include "radiometric_frame_decoder_macros.svh"

module rfd_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rfd_pkg::rfd_entry_t  head,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [95:0]               m_tdata,   // see top level for the field map
    output logic [0:0]                m_tuser,   // [0] kind
    output logic                      m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_SUM  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic out_valid_reg;
    logic out_kind_reg;
    logic out_last_reg;
    logic signed [rfd_pkg::TEMP_W-1:0] out_temp_reg;
    logic                              out_pvalid_reg;
    logic signed [rfd_pkg::TEMP_W-1:0] out_min_reg;
    logic signed [rfd_pkg::TEMP_W-1:0] out_max_reg;
    logic signed [rfd_pkg::TEMP_W-1:0] out_mean_reg;
    logic [rfd_pkg::CNT_W-1:0]         out_count_reg;
    logic [rfd_pkg::STATUS_W-1:0]      out_status_reg;

    logic [rfd_pkg::RAW_W-1:0] snap_min_reg;
    logic [rfd_pkg::RAW_W-1:0] snap_max_reg;
    logic [rfd_pkg::CNT_W-1:0] snap_count_reg;
    logic [rfd_pkg::CNT_W-1:0] snap_total_reg;

    logic out_free;
    logic load_summary;
    logic div_start;
    logic div_busy;
    logic [rfd_pkg::CNT_W-1:0] div_quotient;

    logic [rfd_pkg::NUM_W-1:0] numerator;
    logic                      has_valid;
    logic [20:0]               count_scaled;
    logic [20:0]               total_scaled;
    logic [rfd_pkg::STATUS_W-1:0]      sum_status;
    logic signed [rfd_pkg::TEMP_W-1:0] sum_min;
    logic signed [rfd_pkg::TEMP_W-1:0] sum_max;
    logic signed [rfd_pkg::TEMP_W-1:0] sum_mean;

    assign out_free     = !out_valid_reg || m_tready;
    assign q_pop        = (state_reg == S_IDLE) && !q_empty && out_free;
    assign div_start    = q_pop && head.frame_end;
    assign load_summary = (state_reg == S_SUM) && out_free;

    // raw_sum*25 + count*8, then /16 before the divider
    assign numerator = ({5'd0, head.raw_sum} << 4) + ({5'd0, head.raw_sum} << 3)
                     + {5'd0, head.raw_sum} + ({20'd0, head.good_count} << 3);

    rfd_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (numerator[rfd_pkg::NUM_W-1:4]),
        .divisor  (head.good_count),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_comb begin
        has_valid = (snap_count_reg != '0);
        // too few: count < floor(total*9/10)  <=>  10*(count+1) <= 9*total
        count_scaled = ({4'd0, snap_count_reg} << 3) + ({4'd0, snap_count_reg} << 1)
                     + 21'd10;
        total_scaled = ({4'd0, snap_total_reg} << 3) + {4'd0, snap_total_reg};
        if (has_valid && (snap_max_reg == snap_min_reg)) begin
            sum_status = rfd_pkg::STATUS_CALIBRATION;
        end else if (count_scaled <= total_scaled) begin
            sum_status = rfd_pkg::STATUS_TOO_FEW;
        end else begin
            sum_status = rfd_pkg::STATUS_ACCEPTED;
        end
        if (has_valid) begin
            sum_min  = rfd_pkg::raw_to_centi(snap_min_reg);
            sum_max  = rfd_pkg::raw_to_centi(snap_max_reg);
            sum_mean = $signed({1'b0, div_quotient}) - rfd_pkg::KELVIN_OFFSET;
        end else begin
            sum_min  = '0;
            sum_max  = '0;
            sum_mean = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (div_start) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_busy) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (load_summary) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop || load_summary) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_kind_reg   <= rfd_pkg::KIND_PIXEL;
            out_last_reg   <= !head.frame_end;
            out_temp_reg   <= head.valid ? rfd_pkg::raw_to_centi(head.raw) : '0;
            out_pvalid_reg <= head.valid;
            out_min_reg    <= '0;
            out_max_reg    <= '0;
            out_mean_reg   <= '0;
            out_count_reg  <= '0;
            out_status_reg <= rfd_pkg::STATUS_ACCEPTED;
        end else if (load_summary) begin
            out_kind_reg   <= rfd_pkg::KIND_SUMMARY;
            out_last_reg   <= 1'b1;
            out_temp_reg   <= '0;
            out_pvalid_reg <= 1'b0;
            out_min_reg    <= sum_min;
            out_max_reg    <= sum_max;
            out_mean_reg   <= sum_mean;
            out_count_reg  <= snap_count_reg;
            out_status_reg <= sum_status;
        end
        if (div_start) begin
            snap_min_reg   <= head.min_raw;
            snap_max_reg   <= head.max_raw;
            snap_count_reg <= head.good_count;
            snap_total_reg <= head.total;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_kind_reg;
    assign m_tdata    = {4'd0, out_status_reg, out_count_reg, out_mean_reg, out_max_reg,
                         out_min_reg, out_pvalid_reg, out_temp_reg};

    `RFD_ASSERT(a_summary_is_last, aclk, aresetn,
        out_valid_reg && (out_kind_reg == rfd_pkg::KIND_SUMMARY), out_last_reg,
        "frame summary without tlast")
    `RFD_ASSERT(a_open_frame_busy, aclk, aresetn,
        out_valid_reg && (out_kind_reg == rfd_pkg::KIND_PIXEL) && !out_last_reg,
        state_reg != S_IDLE, "frame-end pixel pending with no summary in progress")
    `RFD_ASSERT(a_sum_after_div, aclk, aresetn, state_reg == S_SUM, !div_busy,
        "summary stage reached while mean division still running")
    `RFD_ASSERT_NEXT(a_frame_end_divides, aclk, aresetn, div_start,
        (state_reg == S_DIV) && div_busy, "frame end did not start the mean division")

endmodule

`default_nettype wire

// ===== rtl/core/radiometric_frame_decoder.sv =====
// Radiometric frame decoder top level: register port, front, queue and back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes raw thermal pixels (1/64 K, little-endian byte pairs) into temperatures in
// 0.01 C and, after the last pixel of each frame, emits a summary item (min, max,
// mean, valid count, status). Pixels flow at one item per cycle while the back part
// is idle and the output is not stalled: a pixel result passes through a queue slot
// and the output register before it is presented on the output. The frame end adds
// a mean division in the back part (one quotient bit per cycle) and then the issue
// of the summary; during that time a 4-item queue keeps taking pixels, then s_tready
// drops until the summary is out. Frame size is frame_width*thermal_rows, each
// clamped to 1..MAX_WIDTH and 1..MAX_ROWS.
// Registers: 0x0 frame_width, 0x4 thermal_rows; write them between frames or idle.
module radiometric_frame_decoder #(
    parameter int unsigned MAX_WIDTH = rfd_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_ROWS  = rfd_pkg::MAX_ROWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] low_byte, [15:8] high_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [17:0] temperature, [18] pixel_valid, [36:19] min_temp, [54:37] max_temp,
    // [72:55] mean_temp, [89:73] valid_count, [91:90] frame_status, [95:92] zero
    output logic [95:0]      m_tdata,
    output logic [0:0]       m_tuser,   // [0] kind
    output logic             m_tlast
);

    logic [rfd_pkg::DIM_W-1:0] frame_width_reg;
    logic [rfd_pkg::DIM_W-1:0] thermal_rows_reg;
    logic                      cfg_write;

    rfd_pkg::rfd_entry_t push_entry;
    rfd_pkg::rfd_entry_t head;
    logic q_push, q_pop, q_empty, q_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= rfd_pkg::FRAME_WIDTH_RST;
            thermal_rows_reg <= rfd_pkg::THERMAL_ROWS_RST;
        end else if (cfg_write) begin
            if (paddr[2] == rfd_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= pwdata[rfd_pkg::DIM_W-1:0];
            end else begin
                thermal_rows_reg <= pwdata[rfd_pkg::DIM_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rfd_pkg::REG_THERMAL_ROWS) begin
            prdata = {{(32-rfd_pkg::DIM_W){1'b0}}, thermal_rows_reg};
        end else begin
            prdata = {{(32-rfd_pkg::DIM_W){1'b0}}, frame_width_reg};
        end
    end

    rfd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (frame_width_reg),
        .thermal_rows (thermal_rows_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (push_entry)
    );

    rfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    rfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb_radiometric_frame_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for radiometric_frame_decoder: stream stimulus, predicted pixel/summary items.

module tb_radiometric_frame_decoder;
    import rfd_pkg::*;

    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RANDOM_ITEMS  = 1150;
    localparam int unsigned SETTLE_CYCLES = 64;

    localparam logic [2:0] ADDR_FRAME_WIDTH  = 3'h0;
    localparam logic [2:0] ADDR_THERMAL_ROWS = 3'h4;

    typedef struct {
        logic                kind;
        logic [TEMP_W-1:0]   temperature;
        logic                pixel_valid;
        logic [TEMP_W-1:0]   min_temp;
        logic [TEMP_W-1:0]   max_temp;
        logic [TEMP_W-1:0]   mean_temp;
        logic [CNT_W-1:0]    valid_count;
        logic [STATUS_W-1:0] frame_status;
        logic                last;
    } decoded_item_t;

    // Tracks frame statistics the way the block does and queues the items it must emit.
    class frame_tracker;
        localparam int unsigned MAX_LINES = 40;

        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] thermal_rows;
        logic [CNT_W-1:0] pixel_index;
        logic [CNT_W-1:0] good_count;
        logic [RAW_W-1:0] min_raw;
        logic [RAW_W-1:0] max_raw;
        logic [SUM_W-1:0] raw_sum;

        decoded_item_t pending_results[$];
        int unsigned   mismatches;
        int unsigned   results_seen;
        int unsigned   status_seen[4];

        function new();
            frame_width  = FRAME_WIDTH_RST;
            thermal_rows = THERMAL_ROWS_RST;
            mismatches   = 0;
            results_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pixel_index = '0;
            good_count  = '0;
            min_raw     = '1;
            max_raw     = '0;
            raw_sum     = '0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_FRAME_WIDTH) frame_width = value[DIM_W-1:0];
            else thermal_rows = value[DIM_W-1:0];
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(frame_width, MAX_WIDTH_DEF) * clamp_dim(thermal_rows, MAX_ROWS_DEF);
        endfunction

        // round half up of raw*25/16, then shift from kelvin to Celsius
        function int centi_of_raw(int unsigned raw);
            return int'((raw * 25 + 8) >> 4) - int'(KELVIN_OFFSET);
        endfunction

        function void take_pixel(logic [7:0] low_byte, logic [7:0] high_byte);
            decoded_item_t     px;
            decoded_item_t     summary;
            logic [RAW_W-1:0]  raw;
            logic              good;
            int unsigned       total;
            longint unsigned   num;
            longint unsigned   den;
            raw   = {high_byte, low_byte};
            good  = raw >= VALID_RAW_MIN;
            total = frame_pixels();
            if (good) begin
                if (raw < min_raw) min_raw = raw;
                if (raw > max_raw) max_raw = raw;
                raw_sum    = raw_sum + SUM_W'(raw);
                good_count = good_count + 1'b1;
            end
            pixel_index = pixel_index + 1'b1;

            px = '{default: 0};
            px.kind        = KIND_PIXEL;
            px.temperature = good ? TEMP_W'(centi_of_raw(raw)) : '0;
            px.pixel_valid = good;
            px.last        = !(pixel_index >= total);
            pending_results.push_back(px);
            if (pixel_index < total) return;

            summary = '{default: 0};
            summary.kind = KIND_SUMMARY;
            if (good_count != 0) begin
                num = longint'(raw_sum) * 25 + longint'(good_count) * 8;
                den = longint'(good_count) * 16;
                summary.min_temp  = TEMP_W'(centi_of_raw(min_raw));
                summary.max_temp  = TEMP_W'(centi_of_raw(max_raw));
                summary.mean_temp = TEMP_W'(int'(num / den) - int'(KELVIN_OFFSET));
            end
            summary.valid_count = good_count;
            // calibration wins over the valid-count threshold
            if (good_count != 0 && max_raw == min_raw) summary.frame_status = STATUS_CALIBRATION;
            else if (good_count < total * 9 / 10) summary.frame_status = STATUS_TOO_FEW;
            else summary.frame_status = STATUS_ACCEPTED;
            summary.last = 1'b1;
            pending_results.push_back(summary);
            clear_frame();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_LINES) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("item %0d %s: got 0x%0h, expected 0x%0h",
                                          results_seen, name, got, want));
        endtask

        task check_result(logic [95:0] data, logic kind, logic last);
            decoded_item_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("item %0d arrived with nothing expected", results_seen));
                return;
            end
            want = pending_results.pop_front();
            check_field("kind",         kind,         want.kind);
            check_field("temperature",  data[17:0],   want.temperature);
            check_field("pixel_valid",  data[18],     want.pixel_valid);
            check_field("min_temp",     data[36:19],  want.min_temp);
            check_field("max_temp",     data[54:37],  want.max_temp);
            check_field("mean_temp",    data[72:55],  want.mean_temp);
            check_field("valid_count",  data[89:73],  want.valid_count);
            check_field("frame_status", data[91:90],  want.frame_status);
            check_field("pad",          data[95:92],  4'd0);
            check_field("last",         last,         want.last);
            if (want.kind == KIND_SUMMARY) status_seen[want.frame_status]++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    frame_tracker tracker = new();

    bit          idling_on    = 1'b1;
    bit          hold_req     = 1'b0;
    int unsigned holds_done   = 0;
    int unsigned items_sent   = 0;
    int unsigned reg_writes   = 0;
    int unsigned stall_cycles = 0;

    radiometric_frame_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [2:0] reg_addr(logic idx);
        return (idx == REG_THERMAL_ROWS) ? ADDR_THERMAL_ROWS : ADDR_FRAME_WIDTH;
    endfunction

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(idx, value);
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic read_register(input logic idx);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = 32'((idx == REG_FRAME_WIDTH) ? tracker.frame_width : tracker.thermal_rows);
        if (prdata !== want)
            tracker.report_mismatch($sformatf("register at 0x%0h read 0x%0h, expected 0x%0h",
                                              reg_addr(idx), prdata, want));
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [15:0] raw);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        tracker.take_pixel(raw[7:0], raw[15:8]);
        items_sent++;
    endtask

    // stop offering and let every predicted item come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_raw(int unsigned bad_pct, bit flat, logic [15:0] base);
        if ($urandom_range(0, 99) < bad_pct)
            return ($urandom_range(0, 7) == 0) ? VALID_RAW_MIN - 1'b1
                                              : 16'($urandom_range(0, VALID_RAW_MIN - 1));
        if (flat) return base;
        case ($urandom_range(0, 15))
            0: return VALID_RAW_MIN;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(VALID_RAW_MIN, 16'hFFFF));
        endcase
    endfunction

    function automatic int unsigned pick_bad_pct();
        case ($urandom_range(0, 7))
            0, 1: return 0;
            2: return 5;
            3: return 10;
            4: return 11;
            5: return 30;
            6: return 50;
            default: return 100;
        endcase
    endfunction

    task automatic run_frame(input int unsigned count, input int unsigned bad_pct, input bit flat);
        logic [15:0] base;
        int unsigned k;
        base = 16'($urandom_range(VALID_RAW_MIN, 16'hFFFF));
        for (k = 0; k < count; k++) send_pixel(pick_raw(bad_pct, flat, base));
        wait_idle();
    endtask

    task automatic random_config();
        logic [31:0] w;
        logic [31:0] r;
        w = $urandom_range(1, 12);
        r = $urandom_range(1, 6);
        case ($urandom_range(0, 19))
            0: w = 0;
            1: begin
                w = $urandom_range(256, 511);
                r = 1;
            end
            2: begin
                w = 1;
                r = $urandom_range(256, 511);
            end
            3: r = 0;
            4: begin
                w = 256;
                r = 2;
            end
            default: ;
        endcase
        // bits above the register width must be dropped
        write_register(REG_FRAME_WIDTH, w | ($urandom() << DIM_W));
        write_register(REG_THERMAL_ROWS, r | ($urandom() << DIM_W));
        read_register(REG_FRAME_WIDTH);
        read_register(REG_THERMAL_ROWS);
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser[0], m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("[%0t] no handshake for %0d cycles, giving up", $time, STALL_LIMIT);
        $display("tb_radiometric_frame_decoder: FAIL");
        $finish;
    end

    initial begin
        int unsigned random_start;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_register(REG_FRAME_WIDTH);
        read_register(REG_THERMAL_ROWS);

        // one-pixel frames: raw extremes and the validity boundary
        write_register(REG_FRAME_WIDTH, 1);
        write_register(REG_THERMAL_ROWS, 1);
        send_pixel(16'h0000);
        send_pixel(16'h2B49);
        send_pixel(16'h2B4A);
        send_pixel(16'hFFFF);
        wait_idle();

        // 2x2 frames; upper write bits are garbage
        write_register(REG_FRAME_WIDTH, 32'hFFFF_FE02);
        write_register(REG_THERMAL_ROWS, 2);
        repeat (4) send_pixel(16'h4E20);            // calibration
        send_pixel(16'h3A98);                       // 3 of 4 valid: accepted
        send_pixel(16'h2B4A);
        send_pixel(16'hFF00);
        send_pixel(16'h00FF);
        send_pixel(16'h5000);                       // calibration and too few
        send_pixel(16'h0001);
        send_pixel(16'h5000);
        send_pixel(16'h2B49);
        send_pixel(16'h0000);                       // nothing valid
        send_pixel(16'h1234);
        send_pixel(16'h2B49);
        send_pixel(16'h00FF);
        wait_idle();

        // frame shrunk under a partial frame: ends on the next pixel
        send_pixel(16'h6000);
        send_pixel(16'h7000);
        wait_idle();
        write_register(REG_THERMAL_ROWS, 1);
        send_pixel(16'h8000);
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        random_start = items_sent;
        write_register(REG_FRAME_WIDTH, 16);
        write_register(REG_THERMAL_ROWS, 4);
        hold_req = 1'b1;
        run_frame(64, 10, 1'b0);

        while (items_sent - random_start < RANDOM_ITEMS) begin
            random_config();
            run_frame(tracker.frame_pixels(), pick_bad_pct(), $urandom_range(0, 4) == 0);
        end

        // full-width frame, no idling: width at its maximum, back-to-back pixels
        idling_on = 1'b0;
        write_register(REG_FRAME_WIDTH, 32'hABCD_E100);
        write_register(REG_THERMAL_ROWS, 2);
        read_register(REG_FRAME_WIDTH);
        read_register(REG_THERMAL_ROWS);
        run_frame(512, 0, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.pending_results.size() != 0)
            tracker.report_mismatch($sformatf("%0d predicted items never arrived",
                                              tracker.pending_results.size()));

        $display("run covered %0d pixel items, %0d output items, %0d register writes, %0d hold-offs",
                 items_sent, tracker.results_seen, reg_writes, holds_done);
        $display("frame summaries: %0d accepted, %0d calibration, %0d too few valid",
                 tracker.status_seen[STATUS_ACCEPTED], tracker.status_seen[STATUS_CALIBRATION],
                 tracker.status_seen[STATUS_TOO_FEW]);
        if (tracker.mismatches == 0) begin
            $display("tb_radiometric_frame_decoder: PASS");
        end else begin
            $display("tb_radiometric_frame_decoder: FAIL");
        end
        $finish;
    end

endmodule
